>>> rtl/tpl_pkg.sv
// Shared types, codes and field widths for the transport playhead loop unit.
// No dependencies; used by every module in rtl/ except tpl_div.
`timescale 1ns / 1ps

package tpl_pkg;

  // default parameter values
  localparam int FRAC_BITS_DEF = 16;
  localparam int TIME_BITS_DEF = 32;

  // fixed field widths
  localparam int ACT_W      = 3;
  localparam int SEEK_W     = 32;
  localparam int CNT_W      = 16;
  localparam int SPD_W      = 11;
  localparam int RATE_W     = 18;
  localparam int MODE_W     = 2;
  localparam int POS_OUT_W  = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 40;

  // actions
  localparam logic [ACT_W-1:0] ACT_PLAY    = 3'd0;
  localparam logic [ACT_W-1:0] ACT_PAUSE   = 3'd1;
  localparam logic [ACT_W-1:0] ACT_STOP    = 3'd2;
  localparam logic [ACT_W-1:0] ACT_TOGGLE  = 3'd3;
  localparam logic [ACT_W-1:0] ACT_SEEK    = 3'd4;
  localparam logic [ACT_W-1:0] ACT_ADVANCE = 3'd5;

  // run modes
  localparam logic [MODE_W-1:0] MODE_STOPPED = 2'd0;
  localparam logic [MODE_W-1:0] MODE_PLAYING = 2'd1;
  localparam logic [MODE_W-1:0] MODE_PAUSED  = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SONG_LENGTH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOOP_ON       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LOOP_BEGIN    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LOOP_FINISH   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_FACTOR  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PLAY_BACKWARD = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_RATE_HZ       = 3'd6;

  localparam logic [SPD_W-1:0]  SPEED_RESET = 11'd256;
  localparam logic [RATE_W-1:0] RATE_RESET  = 18'd48000;

  // controller -> datapath
  typedef struct packed {
    logic accept;     // latch input beat
    logic div_start;  // start delta divide
    logic load_sum;   // register candidate positions
    logic mod_start;  // start loop-length modulo
    logic commit;     // write state and output register
  } tpl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic adv_go;     // incoming beat is an advance that moves
    logic div_busy;   // divider iterating
    logic need_mod;   // candidate falls outside the loop
  } tpl_sts_t;

endpackage

>>> rtl/transport_playhead_loop_unit.sv
// Top level of the transport playhead: stream ports, config port, ctrl + datapath.
// Depends on tpl_pkg, tpl_ctrl, tpl_dp (which holds tpl_div).
`timescale 1ns / 1ps

// Transport playhead with run state and Q(TIME_BITS-FRAC_BITS).FRAC_BITS position.
//
// Input stream (s_*): one command beat per item. s_tuser is the action, s_tdata
// carries seek_time and sample_count. Output stream (m_*): one result beat per
// command with position, run mode and the changed / jumped flags.
// Config port: cfg_valid/cfg_ready with cfg_index and cfg_data; always ready.
// Write registers only while no command is in flight.
//
// Steps, accept to result valid:
//   play, pause, stop, toggle, seek, unknown codes, idle advance: straight to commit.
//   moving advance, no wrap:   delta divide, candidate sum and wrap check, commit.
//   moving advance with wrap:  delta divide, candidate sum and wrap check, loop modulo, commit.
//   Both divides run on the one-bit-per-cycle divider, which is
//   W = max(TIME_BITS, 27 + FRAC_BITS) + 1 bits wide (44 at defaults).
// One command is processed at a time; the next beat is taken as soon as the
// previous result is in the output register, even if that result still waits.
// If the receiver stalls and the output register is full, a finished command
// holds until the register frees; s_tready stays low meanwhile.
// Reset (rst, sync): stopped, position 0, registers to defaults, streams empty.
module transport_playhead_loop_unit #(
  parameter int FRAC_BITS = tpl_pkg::FRAC_BITS_DEF,  // 8..24
  parameter int TIME_BITS = tpl_pkg::TIME_BITS_DEF   // 24..48
) (
  input  logic                              clk,
  input  logic                              rst,
  // config write channel
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [tpl_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tpl_pkg::CFG_DATA_W-1:0]    cfg_data,
  // command stream
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [tpl_pkg::IN_TDATA_W-1:0]    s_tdata,   // [31:0] seek_time, [47:32] sample_count
  input  logic [tpl_pkg::ACT_W-1:0]         s_tuser,   // [2:0] action
  // result stream
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [tpl_pkg::OUT_TDATA_W-1:0]   m_tdata    // [31:0] position_now, [33:32] run_mode,
                                                       // [34] mode_changed, [35] position_jumped
);

  tpl_pkg::tpl_cmd_t cmd;
  tpl_pkg::tpl_sts_t sts;

  // register file has no back pressure
  assign cfg_ready = 1'b1;

  tpl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  tpl_dp #(
    .FRAC_BITS (FRAC_BITS),
    .TIME_BITS (TIME_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_action (s_tuser),
    .in_data   (s_tdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_data  (m_tdata)
  );

endmodule

>>> rtl/tpl_div.sv
// Restoring radix-2 divider, one quotient bit per cycle.
// Standalone; used by tpl_dp for both the delta divide and the loop modulo.
`timescale 1ns / 1ps

module tpl_div #(
  parameter int DDW = 44,  // dividend / quotient width
  parameter int DVW = 32   // divisor / remainder width
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [DDW-1:0] dividend,
  input  logic [DVW-1:0] divisor,
  output logic           busy,
  output logic [DDW-1:0] quotient,
  output logic [DVW-1:0] remainder
);

  localparam int CW = $clog2(DDW + 1);

  logic [CW-1:0]  cnt;
  logic [DDW-1:0] quo;
  logic [DVW-1:0] rem;
  logic [DVW-1:0] dvs;

  logic [DVW:0]   trial;
  logic [DVW:0]   diff;
  logic           ge;

  assign trial = {rem, quo[DDW-1]};
  assign diff  = trial - {1'b0, dvs};
  assign ge    = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= CW'(DDW);
    end else if (cnt != '0) begin
      cnt <= cnt - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (cnt != '0) begin
      quo <= {quo[DDW-2:0], ge};
      rem <= ge ? diff[DVW-1:0] : trial[DVW-1:0];
    end
  end

  assign busy      = cnt != '0;
  assign quotient  = quo;
  assign remainder = rem;

endmodule

>>> rtl/tpl_dp.sv
// Datapath: config registers, transport state, advance arithmetic, output register.
// Depends on tpl_pkg and tpl_div; driven by tpl_ctrl through tpl_cmd_t.
`timescale 1ns / 1ps

module tpl_dp #(
  parameter int FRAC_BITS = tpl_pkg::FRAC_BITS_DEF,
  parameter int TIME_BITS = tpl_pkg::TIME_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [tpl_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tpl_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic [tpl_pkg::ACT_W-1:0]        in_action,
  input  logic [tpl_pkg::IN_TDATA_W-1:0]   in_data,
  input  tpl_pkg::tpl_cmd_t                cmd,
  output tpl_pkg::tpl_sts_t                sts,
  output logic [tpl_pkg::OUT_TDATA_W-1:0]  out_data
);

  localparam int TW = TIME_BITS;
  localparam int PW = tpl_pkg::CNT_W + tpl_pkg::SPD_W;
  localparam int NW = PW + FRAC_BITS;
  localparam int WW = ((TW > NW) ? TW : NW) + 1;
  localparam int DENW = tpl_pkg::RATE_W + 8;
  localparam int DW = (TW > DENW) ? TW : DENW;
  localparam logic [TW-1:0] TMAX = '1;

  // config
  logic [TW-1:0]                  song_len, loop_beg, loop_fin;
  logic                           loop_en, backward;
  logic [tpl_pkg::SPD_W-1:0]      speed;
  logic [tpl_pkg::RATE_W-1:0]     rate;

  // transport state
  logic [tpl_pkg::MODE_W-1:0]     run_state;
  logic [TW-1:0]                  pos;

  // per-item work registers
  logic [tpl_pkg::ACT_W-1:0]      act;
  logic [tpl_pkg::SEEK_W-1:0]     seek;
  logic [PW-1:0]                  prod;
  logic [NW-1:0]                  delta;
  logic [WW-1:0]                  sum_fwd, sum_bwd;
  logic                           wrap;

  // output register
  logic [tpl_pkg::POS_OUT_W-1:0]  out_pos;
  logic [tpl_pkg::MODE_W-1:0]     out_mode;
  logic                           out_chg, out_jmp;

  // divider
  logic           dv_start, dv_busy;
  logic [WW-1:0]  dv_dividend, dv_quo;
  logic [DW-1:0]  dv_divisor, dv_rem;

  logic           loop_act;
  logic [TW-1:0]  loop_len;
  logic [WW-1:0]  mod_x;
  logic           need_mod;

  logic [TW-1:0]                 pos_next;
  logic [tpl_pkg::MODE_W-1:0]    state_next;
  logic                          chg_next, jmp_next;

  function automatic logic [TW-1:0] sat_time(input logic [WW-1:0] v);
    logic [WW-1:0] lim;
    lim = {{(WW - TW){1'b0}}, TMAX};
    sat_time = (v > lim) ? TMAX : v[TW-1:0];
  endfunction

  assign loop_act = loop_en && (loop_fin > loop_beg);
  assign loop_len = loop_fin - loop_beg;

  // config writes, saturating times to the position range
  always_ff @(posedge clk) begin
    if (rst) begin
      song_len <= '0;
      loop_en  <= 1'b0;
      loop_beg <= '0;
      loop_fin <= '0;
      speed    <= tpl_pkg::SPEED_RESET;
      backward <= 1'b0;
      rate     <= tpl_pkg::RATE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        tpl_pkg::REG_SONG_LENGTH:   song_len <= sat_time(WW'(cfg_data));
        tpl_pkg::REG_LOOP_ON:       loop_en  <= cfg_data[0];
        tpl_pkg::REG_LOOP_BEGIN:    loop_beg <= sat_time(WW'(cfg_data));
        tpl_pkg::REG_LOOP_FINISH:   loop_fin <= sat_time(WW'(cfg_data));
        tpl_pkg::REG_SPEED_FACTOR:  speed    <= cfg_data[tpl_pkg::SPD_W-1:0];
        tpl_pkg::REG_PLAY_BACKWARD: backward <= cfg_data[0];
        tpl_pkg::REG_RATE_HZ:       rate     <= cfg_data[tpl_pkg::RATE_W-1:0];
        default: ;
      endcase
    end
  end

  // item capture; product registered before the divide
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      act  <= in_action;
      seek <= in_data[tpl_pkg::SEEK_W-1:0];
      prod <= PW'(in_data[tpl_pkg::SEEK_W +: tpl_pkg::CNT_W]) * PW'(speed);
    end
    if (cmd.load_sum) begin
      delta   <= dv_quo[NW-1:0];
      sum_fwd <= WW'(pos) + dv_quo;
      sum_bwd <= WW'(loop_beg) + dv_quo;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wrap <= 1'b0;
    end else if (cmd.accept) begin
      wrap <= 1'b0;
    end else if (cmd.mod_start) begin
      wrap <= 1'b1;
    end
  end

  // wrap test and modulo operand
  assign need_mod = loop_act &&
                    (backward ? (WW'(pos) < sum_bwd) : (sum_fwd >= WW'(loop_fin)));
  assign mod_x    = backward ? (sum_bwd - WW'(pos)) : (sum_fwd - WW'(loop_beg));

  assign dv_start    = cmd.div_start || cmd.mod_start;
  assign dv_dividend = cmd.mod_start ? mod_x : WW'({prod, {FRAC_BITS{1'b0}}});
  assign dv_divisor  = cmd.mod_start ? DW'(loop_len) : DW'({rate, 8'd0});

  tpl_div #(
    .DDW (WW),
    .DVW (DW)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (dv_start),
    .dividend  (dv_dividend),
    .divisor   (dv_divisor),
    .busy      (dv_busy),
    .quotient  (dv_quo),
    .remainder (dv_rem)
  );

  // command result
  always_comb begin
    pos_next   = pos;
    state_next = run_state;
    chg_next   = 1'b0;
    jmp_next   = 1'b0;
    case (act)
      tpl_pkg::ACT_PLAY, tpl_pkg::ACT_TOGGLE: begin
        if (run_state == tpl_pkg::MODE_PLAYING) begin
          if (act == tpl_pkg::ACT_TOGGLE) begin
            state_next = tpl_pkg::MODE_PAUSED;
            chg_next   = 1'b1;
          end
        end else begin
          if (run_state == tpl_pkg::MODE_STOPPED && song_len != '0 && pos >= song_len) begin
            pos_next = '0;
            jmp_next = 1'b1;
          end
          state_next = tpl_pkg::MODE_PLAYING;
          chg_next   = 1'b1;
        end
      end
      tpl_pkg::ACT_PAUSE: begin
        if (run_state == tpl_pkg::MODE_PLAYING) begin
          state_next = tpl_pkg::MODE_PAUSED;
          chg_next   = 1'b1;
        end
      end
      tpl_pkg::ACT_STOP: begin
        state_next = tpl_pkg::MODE_STOPPED;
        pos_next   = '0;
        chg_next   = 1'b1;
        jmp_next   = 1'b1;
      end
      tpl_pkg::ACT_SEEK: begin
        pos_next = seek[tpl_pkg::SEEK_W-1] ? '0 : sat_time(WW'(seek));
        jmp_next = 1'b1;
      end
      tpl_pkg::ACT_ADVANCE: begin
        if (run_state == tpl_pkg::MODE_PLAYING && rate != '0) begin
          if (!backward) begin
            if (wrap) begin
              pos_next = loop_beg + TW'(dv_rem);
            end else if (!loop_act && song_len != '0 && sum_fwd >= WW'(song_len)) begin
              pos_next   = song_len;
              state_next = tpl_pkg::MODE_STOPPED;
              chg_next   = 1'b1;
            end else begin
              pos_next = sat_time(sum_fwd);
            end
          end else begin
            if (wrap) begin
              pos_next = loop_fin - TW'(dv_rem);
            end else if (!loop_act && WW'(pos) < WW'(delta)) begin
              pos_next   = '0;
              state_next = tpl_pkg::MODE_STOPPED;
              chg_next   = 1'b1;
            end else begin
              pos_next = pos - TW'(delta);
            end
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_state <= tpl_pkg::MODE_STOPPED;
      pos       <= '0;
    end else if (cmd.commit) begin
      run_state <= state_next;
      pos       <= pos_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_pos  <= tpl_pkg::POS_OUT_W'(pos_next);
      out_mode <= state_next;
      out_chg  <= chg_next;
      out_jmp  <= jmp_next;
    end
  end

  assign out_data = {4'b0000, out_jmp, out_chg, out_mode, out_pos};

  assign sts.adv_go   = (in_action == tpl_pkg::ACT_ADVANCE) &&
                        (run_state == tpl_pkg::MODE_PLAYING) && (rate != '0);
  assign sts.div_busy = dv_busy;
  assign sts.need_mod = need_mod;

endmodule

>>> rtl/tpl_ctrl.sv
// Controller FSM: sequences capture, divide, wrap modulo and result commit.
// Depends on tpl_pkg; talks to tpl_dp only through tpl_cmd_t / tpl_sts_t.
`timescale 1ns / 1ps

module tpl_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  output logic               m_tvalid,
  input  logic               m_tready,
  input  tpl_pkg::tpl_sts_t  sts,
  output tpl_pkg::tpl_cmd_t  cmd
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_QSTART = 7'b0000010,
    S_QWAIT  = 7'b0000100,
    S_SUM    = 7'b0001000,
    S_CHK    = 7'b0010000,
    S_RWAIT  = 7'b0100000,
    S_DONE   = 7'b1000000
  } state_t;

  state_t state, state_next;
  logic   out_valid, out_valid_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.accept = 1'b1;
          state_next = sts.adv_go ? S_QSTART : S_DONE;
        end
      end
      S_QSTART: begin
        cmd.div_start = 1'b1;
        state_next    = S_QWAIT;
      end
      S_QWAIT: begin
        if (!sts.div_busy) state_next = S_SUM;
      end
      S_SUM: begin
        cmd.load_sum = 1'b1;
        state_next   = S_CHK;
      end
      S_CHK: begin
        if (sts.need_mod) begin
          cmd.mod_start = 1'b1;
          state_next    = S_RWAIT;
        end else begin
          state_next = S_DONE;
        end
      end
      S_RWAIT: begin
        if (!sts.div_busy) state_next = S_DONE;
      end
      S_DONE: begin
        if (!out_valid || m_tready) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.commit) begin
      out_valid_next = 1'b1;
    end else if (m_tready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  assign s_tready = state == S_IDLE;
  assign m_tvalid = out_valid;

`ifndef ASSERT_OFF
  // never overwrite a result the receiver has not taken
  a_commit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> (!out_valid || m_tready))
    else $error("commit over a pending result");

  // a started divide reports busy on the next cycle
  a_div_runs: assert property (@(posedge clk) disable iff (rst)
    (cmd.div_start || cmd.mod_start) |=> sts.div_busy)
    else $error("divider did not start");

  // an accepted beat holds off the next one in the cycle after the accept
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    cmd.accept |=> !s_tready)
    else $error("second beat taken while busy");

  // a commit always leaves a valid result
  a_commit_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> m_tvalid)
    else $error("result lost after commit");
`endif

endmodule
